### rtl/core/ffsa_pkg.sv
// Package: word types and codes for the first-fit segment allocator.
`default_nettype none
package ffsa_pkg;

    localparam int OFF_W = 20;
    localparam int LEN_W = OFF_W + 1;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_RESIZE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_FIT     = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

    typedef struct packed {
        logic [1:0]       command;
        logic [LEN_W-1:0] request_size;
        logic [OFF_W-1:0] block_offset;
        logic             has_block;
    } req_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             result_valid;
        logic [OFF_W-1:0] result_offset;
        logic             freed_found;
    } rsp_word_t;

endpackage
`default_nettype wire

### rtl/core/first_fit_segment_allocator.sv
// Top level: first-fit segment allocator with a sequenced segment table.
//
// The pool is kept as an address-ordered table of up to MAX_SEGMENTS
// segments held in one memory with a single read and a single write port.
// A request is handled by a small sequencer that walks the table. The lookup
// scans one entry per cycle (read issued, data back from the registered read
// port), while the table shift for a split or a merge reads and then writes
// each entry that it moves. The time a request takes is therefore set by the
// table size and the memory port. in_ready is low while a request is in
// work. After reset entry 0 is loaded before in_ready rises. Writing the pool
// size while idle resets the table to one free segment at once (a write during
// a request is ignored); no clearing pass is needed since entries at or beyond
// the segment count are never read.
`default_nettype none
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [20:0]             cfg_wdata,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire ffsa_pkg::req_word_t     in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output ffsa_pkg::rsp_word_t          out_data
);
    import ffsa_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [LEN_W-1:0] POOL_MAX = LEN_W'(1) << OFF_W;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             free;
    } seg_t;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_FSCAN  = 11'b00000000010,
        S_FNEXT  = 11'b00000000100,
        S_FPREV  = 11'b00000001000,
        S_RMV    = 11'b00000010000,
        S_ASCAN  = 11'b00000100000,
        S_INS    = 11'b00001000000,
        S_SPLIT  = 11'b00010000000,
        S_RESP   = 11'b00100000000,
        S_RDWAIT = 11'b01000000000,
        S_AFIN   = 11'b10000000000
    } state_t;

    // segment memory
    seg_t mem [MAX_SEGMENTS];
    seg_t rd_q;
    logic [IW-1:0] rd_addr, wr_addr;
    logic wr_en;
    seg_t wr_d;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_d;
        end
        rd_q <= mem[rd_addr];
    end

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;      // scan / shift pointer
    logic [CW-1:0] tgt_reg, tgt_next;      // found entry index
    logic [CW-1:0] stop_reg, stop_next;    // gap width of removal shift
    logic [LEN_W-1:0] pool_reg, pool_next;
    logic [LEN_W-1:0] acc_reg, acc_next;   // merged length
    seg_t hold_reg, hold_next;
    req_word_t req_reg, req_next;
    rsp_word_t rsp_reg, rsp_next;
    logic rvalid_reg, rvalid_next;         // rd_q holds valid read data (entry idx-1 while scanning)
    logic [LEN_W-1:0] cfg_sat;
    logic init_reg;                        // entry 0 not loaded yet

    assign cfg_sat = (cfg_wdata > POOL_MAX) ? POOL_MAX : cfg_wdata;
    assign in_ready = (state_reg == S_IDLE) && !out_valid && !init_reg && !cfg_we;
    assign out_data = rsp_reg;
    assign out_valid = (state_reg == S_RESP);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        tgt_next = tgt_reg;
        stop_next = stop_reg;
        pool_next = pool_reg;
        acc_next = acc_reg;
        hold_next = hold_reg;
        req_next = req_reg;
        rsp_next = rsp_reg;
        rvalid_next = 1'b0;
        rd_addr = idx_reg[IW-1:0];
        wr_en = 1'b0;
        wr_addr = '0;
        wr_d = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    pool_next = cfg_sat;
                    cnt_next = CW'(1);
                    wr_en = 1'b1;
                    wr_d = '{start: '0, len: cfg_sat, free: 1'b1};
                end
                else if (init_reg)
                begin
                    wr_en = 1'b1;
                    wr_d = '{start: '0, len: pool_reg, free: 1'b1};
                end
                else if (in_valid && in_ready)
                begin
                    req_next = in_data;
                    rsp_next = '0;
                    idx_next = '0;
                    if ((in_data.command == CMD_FREE || in_data.command == CMD_RESIZE)
                        && in_data.has_block)
                    begin
                        state_next = S_FSCAN;
                    end
                    else if (in_data.command == CMD_ALLOC
                             || in_data.command == CMD_RESIZE)
                    begin
                        state_next = S_ASCAN;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            // free lookup: one entry per cycle, read data registered
            S_FSCAN:
            begin
                rd_addr = idx_reg[IW-1:0];
                if (rvalid_reg && rd_q.start == req_reg.block_offset)
                begin
                    tgt_next = idx_reg - CW'(1);
                    hold_next = rd_q;
                    acc_next = rd_q.len;
                    rsp_next.freed_found = 1'b1;
                    idx_next = idx_reg;  // next entry index = tgt+1
                    state_next = S_FNEXT;
                end
                else if (idx_reg >= cnt_reg)
                begin
                    rsp_next.status = ST_NOT_FOUND;
                    idx_next = '0;
                    state_next = (req_reg.command == CMD_RESIZE) ? S_ASCAN : S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    rvalid_next = 1'b1;
                end
            end
            // read following entry
            S_FNEXT:
            begin
                if (!rvalid_reg)
                begin
                    rd_addr = idx_reg[IW-1:0];
                    rvalid_next = idx_reg < cnt_reg;
                    if (idx_reg >= cnt_reg)
                    begin
                        rd_addr = tgt_reg[IW-1:0] - IW'(1);
                        rvalid_next = 1'b0;
                        state_next = S_FPREV;
                        ret_next = S_IDLE;
                    end
                end
                else
                begin
                    rd_addr = tgt_reg[IW-1:0] - IW'(1);
                    if (rd_q.free)
                    begin
                        acc_next = acc_reg + rd_q.len;
                        ret_next = S_RMV;  // mark: remove tgt+1
                    end
                    else
                    begin
                        ret_next = S_IDLE;
                    end
                    state_next = S_FPREV;
                end
            end
            // previous entry: issue its read here, then merge once the data is back
            S_FPREV:
            begin
                if (!rvalid_reg)
                begin
                    rd_addr = tgt_reg[IW-1:0] - IW'(1);
                    rvalid_next = 1'b1;
                end
                else
                begin
                    if (tgt_reg != '0 && rd_q.free)
                    begin
                        wr_en = 1'b1;
                        wr_addr = tgt_reg[IW-1:0] - IW'(1);
                        wr_d = '{start: rd_q.start, len: rd_q.len + acc_reg, free: 1'b1};
                        // remove tgt (and tgt+1 if merged): shift from there
                        idx_next = tgt_reg;
                        stop_next = (ret_reg == S_RMV) ? CW'(2) : CW'(1);
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        wr_addr = tgt_reg[IW-1:0];
                        wr_d = '{start: hold_reg.start, len: acc_reg, free: 1'b1};
                        idx_next = tgt_reg + CW'(1);
                        stop_next = (ret_reg == S_RMV) ? CW'(1) : CW'(0);
                    end
                    state_next = S_RMV;
                end
            end
            // close gap of stop_reg entries starting at idx: mem[k]=mem[k+stop]
            S_RMV:
            begin
                if (stop_reg == '0 || idx_reg + stop_reg >= cnt_reg)
                begin
                    if (!rvalid_reg)
                    begin
                        cnt_next = cnt_reg - stop_reg;
                        idx_next = '0;
                        state_next = (req_reg.command == CMD_RESIZE) ? S_ASCAN : S_RESP;
                    end
                end
                else if (!rvalid_reg)
                begin
                    rd_addr = IW'(idx_reg + stop_reg);
                    rvalid_next = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_addr = idx_reg[IW-1:0];
                    wr_d = rd_q;
                    idx_next = idx_reg + CW'(1);
                end
            end
            // first-fit scan
            S_ASCAN:
            begin
                rd_addr = idx_reg[IW-1:0];
                if (req_reg.request_size == '0)
                begin
                    rsp_next.result_valid = 1'b1;
                    state_next = S_RESP;
                end
                else if (rvalid_reg && rd_q.free && rd_q.len >= req_reg.request_size)
                begin
                    tgt_next = idx_reg - CW'(1);
                    hold_next = rd_q;
                    if (rd_q.len == req_reg.request_size)
                    begin
                        state_next = S_AFIN;
                    end
                    else if (cnt_reg >= CW'(MAX_SEGMENTS))
                    begin
                        rsp_next.status = ST_TABLE_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        idx_next = cnt_reg;
                        state_next = S_INS;
                    end
                end
                else if (idx_reg >= cnt_reg)
                begin
                    rsp_next.status = ST_NO_FIT;
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    rvalid_next = 1'b1;
                end
            end
            // open a slot: mem[k]=mem[k-1] for k from cnt down to tgt+2
            S_INS:
            begin
                if (idx_reg <= tgt_reg + CW'(1))
                begin
                    state_next = S_SPLIT;
                end
                else if (!rvalid_reg)
                begin
                    rd_addr = IW'(idx_reg - CW'(1));
                    rvalid_next = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_addr = idx_reg[IW-1:0];
                    wr_d = rd_q;
                    idx_next = idx_reg - CW'(1);
                end
            end
            S_SPLIT:
            begin
                wr_en = 1'b1;
                wr_addr = IW'(tgt_reg + CW'(1));
                wr_d = '{start: hold_reg.start + req_reg.request_size[OFF_W-1:0],
                         len: hold_reg.len - req_reg.request_size, free: 1'b1};
                hold_next.len = req_reg.request_size;
                cnt_next = cnt_reg + CW'(1);
                state_next = S_AFIN;
            end
            S_AFIN:
            begin
                wr_en = 1'b1;
                wr_addr = tgt_reg[IW-1:0];
                wr_d = '{start: hold_reg.start, len: hold_reg.len, free: 1'b0};
                rsp_next.result_valid = 1'b1;
                rsp_next.result_offset = hold_reg.start;
                if (rsp_reg.status != ST_NOT_FOUND)
                begin
                    rsp_next.status = ST_OK;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // a no_fit or table_full status wins over not found and clears result_valid
        if (state_reg == S_ASCAN && state_next == S_RESP && rsp_next.status != ST_OK
            && rsp_next.status != ST_NOT_FOUND)
        begin
            rsp_next.result_valid = 1'b0;
        end
        if (state_reg == S_ASCAN && req_reg.request_size == '0)
        begin
            rsp_next.result_offset = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            cnt_reg <= CW'(1);
            pool_reg <= POOL_MAX;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            cnt_reg <= cnt_next;
            pool_reg <= pool_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // entry 0 is loaded once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= 1'b1;
        end
        else if (wr_en && wr_addr == '0)
        begin
            init_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        tgt_reg <= tgt_next;
        stop_reg <= stop_next;
        acc_reg <= acc_next;
        hold_reg <= hold_next;
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_SEGMENTS))
        else $error("segment count overflow");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("ready while busy");
    a_fail_novalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_NO_FIT || out_data.status == ST_TABLE_FULL)
        |-> !out_data.result_valid)
        else $error("failed alloc with valid offset");
endmodule
`default_nettype wire

### verif/ffsa_checker.sv
// Checker: predicts allocator responses and compares them with the block's output words.
module ffsa_checker #(
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [20:0]         cfg_wdata,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire ffsa_pkg::req_word_t in_data,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire ffsa_pkg::rsp_word_t out_data,
    output int                       fail_count,
    output int                       pending_rsp
);
    timeunit 1ns;
    timeprecision 1ps;
    import ffsa_pkg::*;

    localparam logic [LEN_W-1:0] POOL_MAX = LEN_W'(1) << OFF_W;

    // shadow segment table
    logic [OFF_W-1:0] sh_start [MAX_SEGMENTS];
    logic [LEN_W-1:0] sh_len   [MAX_SEGMENTS];
    logic             sh_free  [MAX_SEGMENTS];
    int               sh_count;
    logic [LEN_W-1:0] sh_pool;

    rsp_word_t rsp_queue[$];

    function automatic void table_clear();
        sh_start[0] = '0;
        sh_len[0]   = sh_pool;
        sh_free[0]  = 1'b1;
        sh_count    = 1;
    endfunction

    function automatic void seg_remove(int idx);
        for (int k = idx; k + 1 < sh_count; k++)
        begin
            sh_start[k] = sh_start[k+1];
            sh_len[k]   = sh_len[k+1];
            sh_free[k]  = sh_free[k+1];
        end
        sh_count--;
    endfunction

    function automatic logic release_seg(logic [OFF_W-1:0] off);
        int i;
        i = 0;
        while (i < sh_count && sh_start[i] != off)
            i++;
        if (i >= sh_count)
            return 1'b0;
        sh_free[i] = 1'b1;
        if (i + 1 < sh_count && sh_free[i+1])
        begin
            sh_len[i] += sh_len[i+1];
            seg_remove(i + 1);
        end
        if (i > 0 && sh_free[i-1])
        begin
            sh_len[i-1] += sh_len[i];
            seg_remove(i);
        end
        return 1'b1;
    endfunction

    function automatic logic [1:0] take_seg(logic [LEN_W-1:0] size,
                                            output logic [OFF_W-1:0] off);
        int i;
        off = '0;
        if (size == 0)
            return ST_OK;
        i = 0;
        while (i < sh_count && !(sh_free[i] && sh_len[i] >= size))
            i++;
        if (i >= sh_count)
            return ST_NO_FIT;
        if (sh_len[i] > size)
        begin
            if (sh_count >= MAX_SEGMENTS)
                return ST_TABLE_FULL;
            for (int k = sh_count; k > i + 1; k--)
            begin
                sh_start[k] = sh_start[k-1];
                sh_len[k]   = sh_len[k-1];
                sh_free[k]  = sh_free[k-1];
            end
            sh_start[i+1] = sh_start[i] + OFF_W'(size);
            sh_len[i+1]   = sh_len[i] - size;
            sh_free[i+1]  = 1'b1;
            sh_len[i]     = size;
            sh_count++;
        end
        sh_free[i] = 1'b0;
        off = sh_start[i];
        return ST_OK;
    endfunction

    function automatic rsp_word_t predict_rsp(req_word_t w);
        rsp_word_t r;
        logic [1:0] s;
        logic [OFF_W-1:0] a;
        r = '0;
        if (w.command == CMD_FREE || w.command == CMD_RESIZE)
        begin
            if (w.has_block)
            begin
                r.freed_found = release_seg(w.block_offset);
                if (!r.freed_found)
                    r.status = ST_NOT_FOUND;
            end
        end
        if (w.command == CMD_ALLOC || w.command == CMD_RESIZE)
        begin
            s = take_seg(w.request_size, a);
            if (s == ST_OK)
            begin
                r.result_valid  = 1'b1;
                r.result_offset = a;
            end
            else
                r.status = s;
        end
        return r;
    endfunction

    // track config, accepted requests and returned words
    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t exp_w;
        if (!rst_n)
        begin
            sh_pool = POOL_MAX;
            table_clear();
            rsp_queue.delete();
            fail_count = 0;
            pending_rsp = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                sh_pool = (cfg_wdata > POOL_MAX) ? POOL_MAX : cfg_wdata;
                table_clear();
            end
            if (in_valid && in_ready)
                rsp_queue.push_back(predict_rsp(in_data));
            if (out_valid && out_ready)
            begin
                if (rsp_queue.size() == 0)
                begin
                    $error("unexpected response word %h", out_data);
                    fail_count++;
                end
                else
                begin
                    exp_w = rsp_queue.pop_front();
                    if (out_data.status !== exp_w.status)
                    begin
                        $error("status exp %0d got %0d", exp_w.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.result_valid !== exp_w.result_valid)
                    begin
                        $error("result_valid exp %0d got %0d",
                               exp_w.result_valid, out_data.result_valid);
                        fail_count++;
                    end
                    if (out_data.result_offset !== exp_w.result_offset)
                    begin
                        $error("result_offset exp %0h got %0h",
                               exp_w.result_offset, out_data.result_offset);
                        fail_count++;
                    end
                    if (out_data.freed_found !== exp_w.freed_found)
                    begin
                        $error("freed_found exp %0d got %0d",
                               exp_w.freed_found, out_data.freed_found);
                        fail_count++;
                    end
                end
            end
            pending_rsp = rsp_queue.size();
        end
    end
endmodule

### verif/tb_first_fit_segment_allocator.sv
// Testbench top: stimulus, handshake pacing and verdict for the segment allocator.
module tb_first_fit_segment_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import ffsa_pkg::*;

    localparam int MAXSEG = 64;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [20:0] cfg_wdata = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    req_word_t in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    rsp_word_t out_data;
    int        fail_count;
    int        pending_rsp;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // nonzero offsets handed out so far, used to aim frees at real blocks
    logic [OFF_W-1:0] live_offs[$];
    int unsigned      cur_pool = 1 << OFF_W;

    always #2 clk = ~clk;

    first_fit_segment_allocator #(.MAX_SEGMENTS(MAXSEG)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    ffsa_checker #(.MAX_SEGMENTS(MAXSEG)) chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending_rsp(pending_rsp)
    );

    // receiver: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0 && !hold_done)
        begin
            hold_left <= hold_cycles;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // remember granted offsets from the response stream
    always @(posedge clk)
    begin
        if (cfg_we)
            live_offs.delete();
        else if (out_valid && out_ready && out_data.result_valid
                 && out_data.result_offset != 0)
            live_offs.push_back(out_data.result_offset);
    end

    task automatic send_word(req_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_rsp();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_pool(logic [20:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_pool = (v > (1 << OFF_W)) ? (1 << OFF_W) : 32'(v);
    endtask

    function automatic req_word_t mk(logic [1:0] c, logic [LEN_W-1:0] s,
                                     logic [OFF_W-1:0] o, logic h);
        req_word_t w;
        w.command = c;
        w.request_size = s;
        w.block_offset = o;
        w.has_block = h;
        return w;
    endfunction

    // mostly sized to the pool, with frees aimed at granted offsets
    function automatic req_word_t rand_word();
        req_word_t w;
        int pick;
        int unsigned lim;
        w = '0;
        pick = $urandom_range(99);
        w.command = (pick < 45) ? CMD_ALLOC : (pick < 80) ? CMD_FREE :
                    (pick < 97) ? CMD_RESIZE : CMD_UNUSED;
        lim = (cur_pool == 0) ? 4 : cur_pool;
        case ($urandom_range(3))
            0: w.request_size = LEN_W'($urandom_range(lim / 16 + 1));
            1: w.request_size = LEN_W'($urandom_range(lim / 4 + 1));
            2: w.request_size = LEN_W'($urandom_range(lim + 1));
            default: w.request_size = LEN_W'($urandom);
        endcase
        w.has_block = ($urandom_range(9) != 0);
        if (live_offs.size() > 0 && $urandom_range(9) < 7)
            w.block_offset = live_offs[$urandom_range(live_offs.size() - 1)];
        else if ($urandom_range(1))
            w.block_offset = OFF_W'($urandom);
        else
            w.block_offset = 0;
        return w;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_word(rand_word());
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every command, special cases
        send_word(mk(CMD_ALLOC, 0, 0, 0));
        send_word(mk(CMD_ALLOC, 21'h100000, 0, 0));
        send_word(mk(CMD_ALLOC, 21'h1FFFFF, 20'hFFFFF, 1));
        send_word(mk(CMD_FREE, 0, 0, 1));
        send_word(mk(CMD_FREE, 0, 0, 1));
        send_word(mk(CMD_FREE, 0, 20'hFFFFF, 1));
        send_word(mk(CMD_FREE, 0, 0, 0));
        send_word(mk(CMD_ALLOC, 16, 0, 0));
        send_word(mk(CMD_ALLOC, 32, 0, 0));
        send_word(mk(CMD_ALLOC, 48, 0, 0));
        send_word(mk(CMD_FREE, 0, 16, 1));
        send_word(mk(CMD_FREE, 0, 0, 1));
        send_word(mk(CMD_RESIZE, 40, 48, 1));
        send_word(mk(CMD_RESIZE, 8, 20'h12345, 1));
        send_word(mk(CMD_RESIZE, 21'h1FFFFF, 0, 0));
        send_word(mk(CMD_UNUSED, 21'h1FFFFF, 20'hFFFFF, 1));
        drain_rsp();

        // tiny pool with one-byte splits to fill the table
        write_pool(21'd200);
        for (int i = 0; i < 70; i++)
            send_word(mk(CMD_ALLOC, 1, 0, 0));
        send_word(mk(CMD_FREE, 0, 20'd5, 1));
        send_word(mk(CMD_ALLOC, 1, 0, 0));
        send_word(mk(CMD_ALLOC, 2, 0, 0));
        drain_rsp();

        // zero and oversized pool
        write_pool(21'd0);
        send_word(mk(CMD_ALLOC, 1, 0, 0));
        send_word(mk(CMD_ALLOC, 0, 0, 0));
        drain_rsp();
        write_pool(21'h1FFFFF);
        send_word(mk(CMD_ALLOC, 21'h100000, 0, 0));
        drain_rsp();

        // random phases at various pools and pacing
        write_pool(21'd1);
        run_random(60);
        drain_rsp();

        write_pool(21'd1000);
        run_random(400);
        // sender waits for every result
        drain_rsp();

        send_idle_pct = 78;
        run_random(300);
        send_idle_pct = 0;
        recv_stall_pct = 78;
        run_random(300);
        drain_rsp();

        write_pool(21'h100000);
        send_idle_pct = 31;
        recv_stall_pct = 31;
        run_random(300);
        // long receiver hold-off while input keeps coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 3000;
        run_random(100);
        drain_rsp();

        write_pool(21'd4096);
        run_random(500);
        drain_rsp();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
